/* rtl/rpa_pkg.sv */
// Shared constants, codes and types for the reference-counted pool allocator.
package rpa_pkg;

   localparam int POOL_DEPTH = 64;
   localparam int MAX_REFS   = 255;

   localparam int ADDR_W = $clog2(POOL_DEPTH);
   localparam int LINK_W = $clog2(POOL_DEPTH + 1);
   localparam int PE_W   = $clog2(POOL_DEPTH + 1);
   localparam int CNT_W  = 8;
   localparam int CFG_W  = 7;
   localparam int KIND_W = 2;
   localparam int STS_W  = 3;

   localparam int REQ_TDATA_W = 8 * ((ADDR_W + 7) / 8);
   localparam int RSP_TDATA_W = 8 * ((ADDR_W + CNT_W + 7) / 8);

   localparam logic [LINK_W-1:0] LINK_NONE      = LINK_W'(POOL_DEPTH);
   localparam logic [PE_W-1:0]   POOL_RESET_LEN = PE_W'(POOL_DEPTH);
   localparam logic [CNT_W-1:0]  MAX_COUNT      = CNT_W'(MAX_REFS);

   typedef enum logic [KIND_W-1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_SHARE   = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_UNDEF   = 2'd3
   } req_kind_type;

   typedef enum logic [STS_W-1:0] {
      STS_ALLOCATED = 3'd0,
      STS_EMPTY     = 3'd1,
      STS_SHARED    = 3'd2,
      STS_HELD      = 3'd3,
      STS_FREED     = 3'd4,
      STS_BAD       = 3'd5
   } status_type;

endpackage

/* rtl/rpa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/refcounted_pool_allocator.sv */
// Top level of the reference-counted pool allocator: free list and counts in RAM.
//
//   channel | ports            | direction | content
//   --------+------------------+-----------+-------------------------------------------
//   request | req_t*           | in        | tuser: kind; tdata: handle
//   result  | rsp_t*           | out       | tuser: status; tdata: handle, ref count
//   config  | csr_valid/ready  | in        | csr_data: number of entries in the pool
//
// A request taken in ST_IDLE reads the link and count RAMs at the head or the named
// handle; in ST_EXEC it is modified and written back, the free head is set and the
// result register loaded. The next request is taken in the cycle after the write-back.
// Reset and a configuration write clear per-entry valid bits; an entry without a valid
// bit reads as free with its initial link, so there is no sweep.
// A result that is not taken holds the write-back step until the result register frees.
module refcounted_pool_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rpa_pkg::REQ_TDATA_W-1:0] req_tdata,  // [5:0] handle, rest zero
   input  logic [rpa_pkg::KIND_W-1:0]      req_tuser,  // [1:0] req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rpa_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [5:0] result_handle, [13:6] ref_count
   output logic [rpa_pkg::STS_W-1:0]       rsp_tuser,  // [2:0] status
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rpa_pkg::CFG_W-1:0]       csr_data
);
   import rpa_pkg::*;

   localparam int RSP_PAD = RSP_TDATA_W - ADDR_W - CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [PE_W-1:0]         pool_entries_ff, pool_entries_in;
   logic [LINK_W-1:0]       free_head_ff, free_head_in;
   logic [POOL_DEPTH-1:0]   cnt_vld_ff, cnt_vld_in;
   logic [POOL_DEPTH-1:0]   lnk_vld_ff, lnk_vld_in;
   req_kind_type            kind_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_handle_ff, rsp_handle_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                    req_take;
   logic                    cfg_take;
   logic                    commit;
   logic [ADDR_W-1:0]       rd_addr;
   logic [CNT_W-1:0]        cnt_rdata, cnt_cur;
   logic [LINK_W-1:0]       lnk_rdata, lnk_cur;
   logic                    cnt_we, lnk_we;
   logic [CNT_W-1:0]        cnt_wdata;
   logic [PE_W-1:0]         cfg_len;

   // A configuration write takes priority over a request offered in the same cycle.
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign cfg_take   = csr_valid && csr_ready;
   assign commit     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Allocate reads at the free head, share and release at the named handle.
   assign rd_addr = (req_kind_type'(req_tuser) == REQ_ALLOC) ?
                    free_head_ff[ADDR_W-1:0] : req_tdata[ADDR_W-1:0];

   rpa_ram #(.WIDTH(CNT_W), .DEPTH(POOL_DEPTH)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (addr_ff),
      .wdata (cnt_wdata),
      .re    (req_take),
      .raddr (rd_addr),
      .rdata (cnt_rdata)
   );

   rpa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_lnk_ram (
      .clock (clock),
      .we    (lnk_we),
      .waddr (addr_ff),
      .wdata (free_head_ff),
      .re    (req_take),
      .raddr (rd_addr),
      .rdata (lnk_rdata)
   );

   // Entries never written since the last rebuild read as free with their initial link.
   always_comb begin
      cnt_cur = cnt_vld_ff[addr_ff] ? cnt_rdata : '0;
      if (lnk_vld_ff[addr_ff]) begin
         lnk_cur = lnk_rdata;
      end else if (addr_ff == '0) begin
         lnk_cur = LINK_NONE;
      end else begin
         lnk_cur = LINK_W'(addr_ff) - LINK_W'(1);
      end
   end

   always_comb begin
      if (csr_data == '0) begin
         cfg_len = PE_W'(1);
      end else if (32'(csr_data) > 32'(POOL_DEPTH)) begin
         cfg_len = POOL_RESET_LEN;
      end else begin
         cfg_len = PE_W'(csr_data);
      end
   end

   always_comb begin
      state_in        = state_ff;
      pool_entries_in = pool_entries_ff;
      free_head_in    = free_head_ff;
      cnt_vld_in      = cnt_vld_ff;
      lnk_vld_in      = lnk_vld_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_handle_in   = rsp_handle_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_status_in   = rsp_status_ff;
      cnt_we          = 1'b0;
      lnk_we          = 1'b0;
      cnt_wdata       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cfg_take) begin
               pool_entries_in = cfg_len;
               free_head_in    = LINK_W'(cfg_len - PE_W'(1));
               cnt_vld_in      = '0;
               lnk_vld_in      = '0;
            end else if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_handle_in = addr_ff;
               rsp_count_in  = '0;
               rsp_status_in = STS_BAD;
               case (kind_ff)
                  REQ_ALLOC: begin
                     if (free_head_ff == LINK_NONE) begin
                        rsp_handle_in = '0;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        free_head_in        = lnk_cur;
                        cnt_we              = 1'b1;
                        cnt_wdata           = CNT_W'(1);
                        cnt_vld_in[addr_ff] = 1'b1;
                        rsp_count_in        = CNT_W'(1);
                        rsp_status_in       = STS_ALLOCATED;
                     end
                  end
                  REQ_SHARE: begin
                     if (PE_W'(addr_ff) < pool_entries_ff && cnt_cur != '0) begin
                        if (cnt_cur >= MAX_COUNT) begin
                           rsp_count_in = cnt_cur;
                        end else begin
                           cnt_we              = 1'b1;
                           cnt_wdata           = cnt_cur + CNT_W'(1);
                           cnt_vld_in[addr_ff] = 1'b1;
                           rsp_count_in        = cnt_wdata;
                           rsp_status_in       = STS_SHARED;
                        end
                     end
                  end
                  REQ_RELEASE: begin
                     if (PE_W'(addr_ff) < pool_entries_ff && cnt_cur != '0) begin
                        cnt_we              = 1'b1;
                        cnt_wdata           = cnt_cur - CNT_W'(1);
                        cnt_vld_in[addr_ff] = 1'b1;
                        if (cnt_wdata == '0) begin
                           // Push the entry back on the head of the free list.
                           lnk_we              = 1'b1;
                           lnk_vld_in[addr_ff] = 1'b1;
                           free_head_in        = LINK_W'(addr_ff);
                           rsp_status_in       = STS_FREED;
                        end else begin
                           rsp_count_in  = cnt_wdata;
                           rsp_status_in = STS_HELD;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = STS_BAD;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pool_entries_ff <= POOL_RESET_LEN;
         free_head_ff    <= LINK_W'(POOL_RESET_LEN - PE_W'(1));
         cnt_vld_ff      <= '0;
         lnk_vld_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pool_entries_ff <= pool_entries_in;
         free_head_ff    <= free_head_in;
         cnt_vld_ff      <= cnt_vld_in;
         lnk_vld_ff      <= lnk_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_kind_type'(req_tuser);
         addr_ff <= rd_addr;
      end
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_count_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* rtl/rpa_checker.sv */
// Port-level checker for the pool allocator and its bind to the top level.
module rpa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rpa_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [rpa_pkg::STS_W-1:0]       rsp_tuser
);
   import rpa_pkg::*;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // A held result keeps its valid until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // Only one request is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while another was in work");

   // A new result comes from a request that was accepted and then committed from the execute state without a stall.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_fire, 2))
      else $error("result appeared without a matching request");

   // A fresh allocation always carries a count of one.
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STS_ALLOCATED |-> rsp_tdata[ADDR_W+CNT_W-1:ADDR_W] == 1)
      else $error("allocation with a count other than one");

   // Freed and empty results always report a count of zero.
   a_freed_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STS_FREED || rsp_tuser == STS_EMPTY)
      |-> rsp_tdata[ADDR_W+CNT_W-1:ADDR_W] == 0)
      else $error("freed or empty result with a nonzero count");

endmodule

bind refcounted_pool_allocator rpa_checker u_rpa_checker (.*);

/* tb/sv/refcounted_pool_allocator_tb.sv */
// Self-checking testbench for the reference-counted pool allocator.
module refcounted_pool_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int IDLE_GAP       = 8;
   localparam int DRAIN_CYCLES   = 20;
   localparam int NUM_PHASES     = 9;
   localparam int PHASE_ITEMS    = 110;

   typedef struct packed {
      logic [ADDR_W-1:0] handle;
      status_type        status;
      logic [CNT_W-1:0]  count;
   } pool_result_type;

   // Tracks the free list and reference counts and holds the results still owed.
   class pool_scoreboard_type;
      int                entries;
      logic [LINK_W-1:0] head;
      logic [LINK_W-1:0] link [POOL_DEPTH];
      logic [CNT_W-1:0]  refs [POOL_DEPTH];
      logic [LINK_W-1:0] last_grant;
      pool_result_type   outcome_q [$];
      int                errors;
      int                requests;
      int                results;
      int                status_seen [6];

      function new();
         errors   = 0;
         requests = 0;
         results  = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         load_pool_size(CFG_W'(POOL_DEPTH));
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      function void load_pool_size(logic [CFG_W-1:0] value);
         int n;
         n = value;
         if (n < 1) n = 1;
         if (n > POOL_DEPTH) n = POOL_DEPTH;
         entries = n;
         for (int i = 0; i < POOL_DEPTH; i++) begin
            refs[i] = '0;
            link[i] = (i == 0) ? LINK_NONE : LINK_W'(i - 1);
         end
         head = LINK_W'(entries - 1);
      endfunction

      // Returns a random entry that is currently held, or -1 if none is.
      function int pick_held();
         int held [$];
         for (int i = 0; i < entries; i++)
            if (refs[i] != 0) held.push_back(i);
         if (held.size() == 0) return -1;
         return held[$urandom_range(0, held.size() - 1)];
      endfunction

      function void note_request(req_kind_type kind, logic [ADDR_W-1:0] h);
         pool_result_type   r;
         logic [ADDR_W-1:0] e;
         int                c;
         requests++;
         r.handle = h;
         r.status = STS_BAD;
         r.count  = '0;
         if (kind == REQ_ALLOC) begin
            if (head >= LINK_W'(POOL_DEPTH)) begin
               r.handle = '0;
               r.status = STS_EMPTY;
            end else begin
               e          = head[ADDR_W-1:0];
               r.handle   = e;
               r.status   = STS_ALLOCATED;
               r.count    = CNT_W'(1);
               refs[e]    = CNT_W'(1);
               last_grant = head;
               head       = link[e];
            end
         end else if (kind != REQ_UNDEF && h < entries && refs[h] != 0) begin
            c = refs[h];
            if (kind == REQ_SHARE) begin
               // A share at the ceiling is rejected but still reports the count.
               if (c >= MAX_REFS) begin
                  r.count = CNT_W'(c);
               end else begin
                  c++;
                  refs[h]  = CNT_W'(c);
                  r.status = STS_SHARED;
                  r.count  = CNT_W'(c);
               end
            end else begin
               c--;
               refs[h] = CNT_W'(c);
               if (c == 0) begin
                  link[h]  = head;
                  head     = LINK_W'(h);
                  r.status = STS_FREED;
               end else begin
                  r.status = STS_HELD;
                  r.count  = CNT_W'(c);
               end
            end
         end
         outcome_q.push_back(r);
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] data, logic [STS_W-1:0] user);
         pool_result_type   want;
         logic [ADDR_W-1:0] got_handle;
         logic [CNT_W-1:0]  got_count;
         got_handle = data[ADDR_W-1:0];
         got_count  = data[ADDR_W +: CNT_W];
         if (outcome_q.size() == 0) begin
            errors++;
            $display("%0t: result with no request outstanding: handle %0d status %0d count %0d",
                     $time, got_handle, user, got_count);
            return;
         end
         want = outcome_q.pop_front();
         results++;
         status_seen[int'(want.status)]++;
         if (got_handle !== want.handle) begin
            errors++;
            $display("%0t: result handle mismatch: expected %0d actual %0d",
                     $time, want.handle, got_handle);
         end
         if (user !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, user);
         end
         if (got_count !== want.count) begin
            errors++;
            $display("%0t: ref count mismatch: expected %0d actual %0d",
                     $time, want.count, got_count);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STS_W-1:0]       rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_data;

   pool_scoreboard_type sb;
   int                  burst_left = 0;
   int                  idle_cycles = 0;
   int                  sizes_written = 0;

   refcounted_pool_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Ends a burst now and then with a random gap on the request side.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_request(req_kind_type kind, logic [ADDR_W-1:0] handle);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TDATA_W'(handle);
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, handle);
      pace();
   endtask

   // The pool size is only changed once every owed result has come back.
   task automatic write_pool_size(logic [CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.load_pool_size(value);
      sizes_written++;
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed traffic on held handles, with some noise mixed in.
   task automatic random_request(int alloc_pct);
      int roll;
      int h;
      roll = $urandom_range(0, 99);
      h    = sb.pick_held();
      if (roll < 8)
         send_request(req_kind_type'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 63)));
      else if (roll < 8 + alloc_pct || h < 0)
         send_request(REQ_ALLOC, ADDR_W'($urandom_range(0, 63)));
      else if ($urandom_range(0, 9) < 4)
         send_request(REQ_SHARE, ADDR_W'(h));
      else
         send_request(REQ_RELEASE, ADDR_W'(h));
   endtask

   // Result side: segments of differing readiness, with a long hold-off every so often.
   initial begin
      int segment;
      int ready_pct;
      rsp_tready = 1'b0;
      segment    = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         segment++;
         if (segment % 8 == 3) begin
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_tready <= 1'b0;
            end
         end else begin
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 50;
               2: ready_pct = 90;
               default: ready_pct = 20;
            endcase
            repeat ($urandom_range(20, 200)) begin
               @(posedge clock);
               rsp_tready <= ($urandom_range(0, 99) < ready_pct);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: nothing accepted for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, sb.pending());
            $display("refcounted_pool_allocator_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int               pool_sizes [NUM_PHASES];
      logic [ADDR_W-1:0] hot;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_ALLOC;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Full pool from reset: LIFO order, sharing, freeing and misuse of free entries.
      send_request(REQ_ALLOC, 6'd0);
      send_request(REQ_ALLOC, 6'd63);
      send_request(REQ_SHARE, 6'd63);
      send_request(REQ_SHARE, 6'd63);
      send_request(REQ_RELEASE, 6'd63);
      send_request(REQ_RELEASE, 6'd62);
      send_request(REQ_RELEASE, 6'd62);
      send_request(REQ_SHARE, 6'd62);
      send_request(REQ_UNDEF, 6'd63);
      send_request(REQ_UNDEF, 6'd0);
      send_request(REQ_SHARE, 6'd0);
      send_request(REQ_ALLOC, 6'd0);

      // Single-entry pool: empty pool and handles beyond the pool.
      write_pool_size(CFG_W'(1));
      send_request(REQ_ALLOC, 6'd63);
      send_request(REQ_ALLOC, 6'd0);
      send_request(REQ_SHARE, 6'd1);
      send_request(REQ_RELEASE, 6'd63);
      send_request(REQ_SHARE, 6'd0);
      send_request(REQ_RELEASE, 6'd0);
      send_request(REQ_RELEASE, 6'd0);
      send_request(REQ_ALLOC, 6'd0);

      // Register values outside the range saturate.
      write_pool_size(CFG_W'(0));
      send_request(REQ_ALLOC, 6'd0);
      send_request(REQ_ALLOC, 6'd0);
      write_pool_size(CFG_W'(127));
      send_request(REQ_ALLOC, 6'd0);
      send_request(REQ_RELEASE, 6'd63);

      pool_sizes = '{64, 1, 2, 127, 0, 3, 0, 0, 64};
      pool_sizes[6] = $urandom_range(4, 16);
      pool_sizes[7] = $urandom_range(0, 127);
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_pool_size(CFG_W'(pool_sizes[p]));
         repeat (PHASE_ITEMS) random_request($urandom_range(20, 70));
      end

      // Drive one entry to the count ceiling and back down to free.
      write_pool_size(CFG_W'($urandom_range(1, POOL_DEPTH)));
      send_request(REQ_ALLOC, ADDR_W'($urandom_range(0, 63)));
      hot = sb.last_grant[ADDR_W-1:0];
      repeat (MAX_REFS + 2) send_request(REQ_SHARE, hot);
      repeat (MAX_REFS + 1) send_request(REQ_RELEASE, hot);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results for %0d requests across %0d register writes.",
               sb.results, sb.requests, sizes_written);
      $display("Allocated %0d, empty %0d, shared %0d, held %0d, freed %0d, rejected %0d.",
               sb.status_seen[STS_ALLOCATED], sb.status_seen[STS_EMPTY],
               sb.status_seen[STS_SHARED], sb.status_seen[STS_HELD],
               sb.status_seen[STS_FREED], sb.status_seen[STS_BAD]);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("refcounted_pool_allocator_tb: PASS");
      else
         $display("refcounted_pool_allocator_tb: FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/rpa_pkg.sv
rtl/rpa_ram.sv
rtl/refcounted_pool_allocator.sv
rtl/rpa_checker.sv
tb/sv/refcounted_pool_allocator_tb.sv
